FILE: sv/vn1d_pkg.sv
package vn1d_pkg;

    // request kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // fade curve select
    localparam logic [1:0] FADE_COS     = 2'd0;
    localparam logic [1:0] FADE_SMOOTH  = 2'd1;
    localparam logic [1:0] FADE_QUINTIC = 2'd2;

    localparam int COORD_W   = 24;
    localparam int INDEX_W   = 8;
    localparam int ENTRY_W   = 16;
    localparam int NOISE_W   = 16;
    localparam int S_TDATA_W = 48;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [17:0] THREE_Q16 = 18'h30000;
    localparam logic [20:0] TEN_Q16  = 21'd655360;

    // (1 - cos(pi*t))/2 at steps of 1/16, Q16
    function automatic logic [16:0] cos_fade(input logic [4:0] k);
        logic [16:0] c;
        case (k)
            5'd0:    c = 17'd0;
            5'd1:    c = 17'd630;
            5'd2:    c = 17'd2494;
            5'd3:    c = 17'd5522;
            5'd4:    c = 17'd9598;
            5'd5:    c = 17'd14563;
            5'd6:    c = 17'd20228;
            5'd7:    c = 17'd26375;
            5'd8:    c = 17'd32768;
            5'd9:    c = 17'd39161;
            5'd10:   c = 17'd45308;
            5'd11:   c = 17'd50973;
            5'd12:   c = 17'd55938;
            5'd13:   c = 17'd60014;
            5'd14:   c = 17'd63042;
            5'd15:   c = 17'd64906;
            default: c = 17'd65536;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/value_noise_1d_eval_unit.sv
// One-dimensional value noise. A load word (tuser = 0) writes one lattice entry;
// an evaluate word (tuser = 1) returns the noise at a signed fixed-point coordinate,
// blending the two neighboring lattice entries through the fade curve chosen by
// fade_mode (0 cosine, 1 smoothstep, 2 quintic, 3 acts as smoothstep). The block
// takes one word per clock while m_axis_tready does not stall it; loads give no
// result. An evaluate result passes through the registered lattice read port, two
// fade multiplier stages, the blend multipliers and the output register. Only
// m_axis_tready stalls the pipeline, and empty stages keep filling while a result
// waits. Every lattice entry must be loaded before it is evaluated.
// fade_mode may only change while no evaluate word is in flight.
module value_noise_1d_eval_unit #(
    parameter int PERIOD     = 256,
    parameter int FRAC_BITS  = 12,
    parameter int VALUE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,     // fade_mode

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // [23:0] coord, [31:24] entry_index, [47:32] entry_value
    input  logic        s_axis_tuser,    // [0] req_type

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // [15:0] noise_value
);
    import vn1d_pkg::*;

    localparam int IDX_W = $clog2(PERIOD);
    localparam int OUT_W = (VALUE_BITS < NOISE_W) ? VALUE_BITS : NOISE_W;
    localparam int CEXT_W = 48;

    // ---------------- configuration ----------------
    logic [1:0] fade_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_mode_reg <= FADE_SMOOTH;
        end else if (cfg_wr_en) begin
            fade_mode_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage valids and flow ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdyo;

    logic                  req1_reg;
    logic [COORD_W-1:0]    coord1_reg;
    logic [IDX_W-1:0]      idx1_reg;
    logic [VALUE_BITS-1:0] val1_reg;

    // loads retire out of stage 1 without waiting on the tail
    assign rdyo = !vo_reg || m_axis_tready;
    assign rdy5 = !v5_reg || rdyo;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || (req1_reg == REQ_LOAD) || rdy2;

    assign s_axis_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg && (req1_reg == REQ_EVAL);
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdyo) vo_reg <= v5_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            req1_reg   <= s_axis_tuser;
            coord1_reg <= s_axis_tdata[23:0];
            idx1_reg   <= IDX_W'(32'(s_axis_tdata[31:24]));
            val1_reg   <= VALUE_BITS'(48'(s_axis_tdata[47:32]));
        end
    end

    logic [CEXT_W-1:0] cext1;
    logic [IDX_W-1:0]  base1, succ1;
    logic [15:0]       t16_1;
    logic [31:0]       sq1;
    logic [15:0]       t2_next;
    logic [16:0]       clo_next, chi1;
    logic [12:0]       cdiff_next;

    always_comb begin
        cext1 = {{(CEXT_W - COORD_W){coord1_reg[COORD_W-1]}}, coord1_reg};
        // floor: integer part is everything above the fraction, two's complement
        base1 = cext1[FRAC_BITS +: IDX_W];
        succ1 = base1 + IDX_W'(1);
        t16_1 = 16'(32'(cext1[FRAC_BITS-1:0]) << (16 - FRAC_BITS));
        sq1 = 32'(t16_1) * 32'(t16_1);
        t2_next = sq1[31:16];
        clo_next = cos_fade({1'b0, t16_1[15:12]});
        chi1 = cos_fade(5'({1'b0, t16_1[15:12]}) + 5'd1);
        cdiff_next = 13'(chi1 - clo_next);
    end

    // ---------------- lattice memory ----------------
    logic [VALUE_BITS-1:0] lattice_mem [PERIOD];
    logic [VALUE_BITS-1:0] a2_reg, b2_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && v1_reg && (req1_reg == REQ_LOAD)) begin
            lattice_mem[idx1_reg] <= val1_reg;
        end
        if (rdy2) begin
            a2_reg <= lattice_mem[base1];
            b2_reg <= lattice_mem[succ1];
        end
    end

    // ---------------- stage 2 ----------------
    logic [15:0] t16_2_reg, t2_2_reg;
    logic [16:0] clo2_reg;
    logic [12:0] cdiff2_reg;
    logic [11:0] r2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            t16_2_reg  <= t16_1;
            t2_2_reg   <= t2_next;
            clo2_reg   <= clo_next;
            cdiff2_reg <= cdiff_next;
            r2_reg     <= t16_1[11:0];
        end
    end

    logic [17:0] smul2;
    logic [33:0] smprod_next;
    logic [31:0] tp2;
    logic [15:0] t3_next;
    logic [20:0] p_next;
    logic [24:0] cprod_next;

    always_comb begin
        smul2 = THREE_Q16 - 18'({t16_2_reg, 1'b0});
        smprod_next = 34'(t2_2_reg) * 34'(smul2);
        tp2 = 32'(t2_2_reg) * 32'(t16_2_reg);
        t3_next = tp2[31:16];
        // 10 - 15t + 6t^2 stays positive; intermediate wrap is harmless
        p_next = TEN_Q16 + 21'(t2_2_reg) * 21'd6 - 21'(t16_2_reg) * 21'd15;
        cprod_next = 25'(cdiff2_reg) * 25'(r2_reg);
    end

    // ---------------- stage 3 ----------------
    logic [VALUE_BITS-1:0] a3_reg, b3_reg;
    logic [33:0] smprod3_reg;
    logic [15:0] t3_3_reg;
    logic [20:0] p3_reg;
    logic [16:0] clo3_reg;
    logic [24:0] cprod3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            a3_reg      <= a2_reg;
            b3_reg      <= b2_reg;
            smprod3_reg <= smprod_next;
            t3_3_reg    <= t3_next;
            p3_reg      <= p_next;
            clo3_reg    <= clo2_reg;
            cprod3_reg  <= cprod_next;
        end
    end

    logic [36:0] qprod3;
    logic [37:0] qsum3;
    logic [34:0] ssum3;
    logic [25:0] csum3;
    logic [16:0] f_next;

    always_comb begin
        qprod3 = 37'(t3_3_reg) * 37'(p3_reg);
        qsum3 = 38'(qprod3) + 38'd32768;
        ssum3 = 35'(smprod3_reg) + 35'd32768;
        csum3 = 26'(cprod3_reg) + 26'd2048;
        case (fade_mode_reg)
            FADE_COS:     f_next = clo3_reg + 17'(csum3[25:12]);
            FADE_QUINTIC: f_next = (qsum3[37:16] > 22'(ONE_Q16)) ? ONE_Q16 : qsum3[32:16];
            default:      f_next = ssum3[32:16];
        endcase
    end

    // ---------------- stage 4 ----------------
    logic [VALUE_BITS-1:0] a4_reg, b4_reg;
    logic [16:0] f4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            a4_reg <= a3_reg;
            b4_reg <= b3_reg;
            f4_reg <= f_next;
        end
    end

    logic [16:0] wa4;
    logic [VALUE_BITS+16:0] pa_next, pb_next;

    always_comb begin
        wa4 = ONE_Q16 - f4_reg;
        pa_next = (VALUE_BITS+17)'(a4_reg) * (VALUE_BITS+17)'(wa4);
        pb_next = (VALUE_BITS+17)'(b4_reg) * (VALUE_BITS+17)'(f4_reg);
    end

    // ---------------- stage 5 ----------------
    logic [VALUE_BITS+16:0] pa5_reg, pb5_reg;

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            pa5_reg <= pa_next;
            pb5_reg <= pb_next;
        end
    end

    logic [VALUE_BITS+17:0] sum5;
    logic [VALUE_BITS-1:0]  blend5;
    logic [NOISE_W-1:0]     noise_next;

    always_comb begin
        sum5 = (VALUE_BITS+18)'(pa5_reg) + (VALUE_BITS+18)'(pb5_reg)
             + (VALUE_BITS+18)'(32768);
        // weights sum to one, so the blend never exceeds the larger entry
        blend5 = sum5[16 +: VALUE_BITS];
        noise_next = NOISE_W'(blend5[OUT_W-1:0]);
    end

    // ---------------- output register ----------------
    logic [NOISE_W-1:0] noise_reg;

    always_ff @(posedge aclk) begin
        if (rdyo) begin
            noise_reg <= noise_next;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = noise_reg;

    // ---------------- checks ----------------
    a_load_never_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2 && (req1_reg == REQ_LOAD)) |=> !v2_reg)
        else $error("load word entered the evaluate pipeline");

    a_fade_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (f4_reg <= ONE_Q16))
        else $error("fade weight above one");

    a_stall_from_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && v1_reg && v2_reg))
        else $error("input stalled with a free stage");

    a_blend_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg |-> (sum5[VALUE_BITS+17 -: 2] == 2'b00))
        else $error("blend result overflows value width");

endmodule
